// ===== rtl/core/bcdac_pkg.sv =====
// Shared types, opcodes, error codes and constants for the BCD arithmetic unit.
// No dependencies.
`default_nettype none

package bcdac_pkg;

    localparam int NIB_N      = 16;          // nibbles in a packed BCD word
    localparam int BCD_W      = 64;
    localparam int BIN_W      = 54;          // 10^16-1 < 2^54
    localparam int HALF_W     = 27;
    localparam int GRP_W      = 14;          // four digits, up to 9999
    localparam int DD_STEPS   = 6;           // double-dabble bits per stage
    localparam int DD_STAGES  = BIN_W / DD_STEPS;
    localparam int DIGITS_DEF = 16;

    localparam logic [26:0] GRP_SCALE  = 27'd10000;
    localparam logic [53:0] HALF_SCALE = 54'd100000000;

    typedef enum logic [1:0] {
        OP_BIN2BCD = 2'd0,
        OP_BCD2BIN = 2'd1,
        OP_ADD     = 2'd2,
        OP_MUL     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_BAD      = 2'd2
    } err_t;

    // decoded operands, leaving the decode stages
    typedef struct packed {
        logic               vld;
        op_t                op;
        logic               bad;
        logic [BCD_W-1:0]   a;
        logic [BIN_W-1:0]   x;
        logic [BIN_W-1:0]   y;
    } opnd_t;

    // conversion stage state
    typedef struct packed {
        logic               vld;
        op_t                op;
        err_t               err;
        logic [BIN_W-1:0]   bin;
        logic [BIN_W-1:0]   val;
        logic [BCD_W-1:0]   bcd;
    } conv_t;

    function automatic logic [63:0] pow10_lim(input int n);
        logic [63:0] m;
        m = 64'd0;
        for (int i = 0; i < n && i < NIB_N; i++)
        begin
            m = 64'(m * 64'd10) + 64'd9;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcd_arith_convert_unit.sv =====
// Top level of the packed BCD add / multiply / conversion unit.
// Depends on bcdac_pkg, bcdac_decode, bcdac_mult, bcdac_dabble_stage.
`default_nettype none

// Fully pipelined: one transfer accepted per cycle while the pipe advances, result registered through
// 3 decode stages, 3 add/multiply/range stages, DD_STAGES = 9 binary-to-BCD
// stages of 6 bits each and 1 output register. The whole pipe advances when the
// output register is empty or being taken, so m_tready low freezes every stage.
// Opcode rides in s_tuser, error code in m_tuser; result is 0 on any error.
module bcd_arith_convert_unit #(
    parameter int DIGITS = bcdac_pkg::DIGITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // operand_a[63:0], operand_b[127:64]
    input  wire logic [1:0]    s_tuser,   // opcode[1:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // result_value[63:0]
    output logic [1:0]         m_tuser    // error_code[1:0]
);
    import bcdac_pkg::*;

    logic             en;
    opnd_t            opnd;
    conv_t            chain [DD_STAGES+1];
    logic             vld_reg;
    logic [63:0]      res_reg, res_next;
    err_t             err_reg;

    assign en       = !vld_reg || m_tready;
    assign s_tready = en;

    bcdac_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (s_tvalid),
        .in_op  (op_t'(s_tuser)),
        .in_a   (s_tdata[63:0]),
        .in_b   (s_tdata[127:64]),
        .opnd   (opnd)
    );

    bcdac_mult #(
        .DIGITS (DIGITS)
    ) u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .opnd   (opnd),
        .conv   (chain[0])
    );

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dd
        bcdac_dabble_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    always_comb
    begin
        if (chain[DD_STAGES].err != ERR_OK)
            res_next = '0;
        else if (chain[DD_STAGES].op == OP_BCD2BIN)
            res_next = 64'(chain[DD_STAGES].bin);
        else
            res_next = chain[DD_STAGES].bcd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            res_reg <= '0;
            err_reg <= ERR_OK;
        end
        else if (en)
        begin
            vld_reg <= chain[DD_STAGES].vld;
            res_reg <= res_next;
            err_reg <= chain[DD_STAGES].err;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = err_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcdac_decode.sv =====
// Three-stage packed BCD to binary decode with digit check.
// Depends on bcdac_pkg.
`default_nettype none

module bcdac_decode (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_vld,
    input  wire bcdac_pkg::op_t           in_op,
    input  wire logic [63:0]              in_a,
    input  wire logic [63:0]              in_b,
    output bcdac_pkg::opnd_t              opnd
);
    import bcdac_pkg::*;

    typedef struct packed {
        logic             vld;
        op_t              op;
        logic             bad;
        logic [BCD_W-1:0] a;
        logic [GRP_W-1:0] ga3, ga2, ga1, ga0;
        logic [GRP_W-1:0] gb3, gb2, gb1, gb0;
    } s1_t;

    typedef struct packed {
        logic               vld;
        op_t                op;
        logic               bad;
        logic [BCD_W-1:0]   a;
        logic [HALF_W-1:0]  ah, al, bh, bl;
    } s2_t;

    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    opnd_t s3_reg, s3_next;

    function automatic logic nib_bad(input logic [63:0] v);
        logic r;
        r = 1'b0;
        for (int i = 0; i < NIB_N; i++)
        begin
            if (v[4*i +: 4] > 4'd9)
                r = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [GRP_W-1:0] grp4(input logic [15:0] v);
        logic [GRP_W-1:0] r;
        r = GRP_W'(v[15:12]);
        r = GRP_W'(r * GRP_W'(10)) + GRP_W'(v[11:8]);
        r = GRP_W'(r * GRP_W'(10)) + GRP_W'(v[7:4]);
        r = GRP_W'(r * GRP_W'(10)) + GRP_W'(v[3:0]);
        return r;
    endfunction

    always_comb
    begin
        s1_next.vld = in_vld;
        s1_next.op  = in_op;
        s1_next.a   = in_a;
        case (in_op)
            OP_BIN2BCD: s1_next.bad = 1'b0;
            OP_BCD2BIN: s1_next.bad = nib_bad(in_a);
            default:    s1_next.bad = nib_bad(in_a) | nib_bad(in_b);
        endcase
        s1_next.ga3 = grp4(in_a[63:48]);
        s1_next.ga2 = grp4(in_a[47:32]);
        s1_next.ga1 = grp4(in_a[31:16]);
        s1_next.ga0 = grp4(in_a[15:0]);
        s1_next.gb3 = grp4(in_b[63:48]);
        s1_next.gb2 = grp4(in_b[47:32]);
        s1_next.gb1 = grp4(in_b[31:16]);
        s1_next.gb0 = grp4(in_b[15:0]);
    end

    always_comb
    begin
        s2_next.vld = s1_reg.vld;
        s2_next.op  = s1_reg.op;
        s2_next.bad = s1_reg.bad;
        s2_next.a   = s1_reg.a;
        s2_next.ah  = HALF_W'(HALF_W'(s1_reg.ga3) * GRP_SCALE) + HALF_W'(s1_reg.ga2);
        s2_next.al  = HALF_W'(HALF_W'(s1_reg.ga1) * GRP_SCALE) + HALF_W'(s1_reg.ga0);
        s2_next.bh  = HALF_W'(HALF_W'(s1_reg.gb3) * GRP_SCALE) + HALF_W'(s1_reg.gb2);
        s2_next.bl  = HALF_W'(HALF_W'(s1_reg.gb1) * GRP_SCALE) + HALF_W'(s1_reg.gb0);
    end

    always_comb
    begin
        s3_next.vld = s2_reg.vld;
        s3_next.op  = s2_reg.op;
        s3_next.bad = s2_reg.bad;
        s3_next.a   = s2_reg.a;
        s3_next.x   = BIN_W'(BIN_W'(s2_reg.ah) * HALF_SCALE) + BIN_W'(s2_reg.al);
        s3_next.y   = BIN_W'(BIN_W'(s2_reg.bh) * HALF_SCALE) + BIN_W'(s2_reg.bl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign opnd = s3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcdac_mult.sv =====
// Three-stage sum, split product and range check; picks the value to encode.
// Depends on bcdac_pkg.
`default_nettype none

module bcdac_mult #(
    parameter int DIGITS = bcdac_pkg::DIGITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire bcdac_pkg::opnd_t     opnd,
    output bcdac_pkg::conv_t          conv
);
    import bcdac_pkg::*;

    localparam logic [63:0] LIM = pow10_lim(DIGITS);
    localparam int PP_W = 2 * HALF_W;
    localparam int P_W  = 2 * BIN_W;

    typedef struct packed {
        logic              vld;
        op_t               op;
        logic              bad;
        logic [BCD_W-1:0]  a;
        logic [BIN_W-1:0]  x;
        logic [BIN_W:0]    s;
        logic [PP_W-1:0]   ll, lh, hl, hh;
    } s4_t;

    typedef struct packed {
        logic              vld;
        op_t               op;
        logic              bad;
        logic [BCD_W-1:0]  a;
        logic [BIN_W-1:0]  x;
        logic [BIN_W:0]    s;
        logic [P_W-1:0]    p;
    } s5_t;

    s4_t   s4_reg, s4_next;
    s5_t   s5_reg, s5_next;
    conv_t s6_reg, s6_next;

    always_comb
    begin
        s4_next.vld = opnd.vld;
        s4_next.op  = opnd.op;
        s4_next.bad = opnd.bad;
        s4_next.a   = opnd.a;
        s4_next.x   = opnd.x;
        s4_next.s   = (BIN_W+1)'(opnd.x) + (BIN_W+1)'(opnd.y);
        s4_next.ll  = PP_W'(opnd.x[HALF_W-1:0]) * PP_W'(opnd.y[HALF_W-1:0]);
        s4_next.lh  = PP_W'(opnd.x[HALF_W-1:0]) * PP_W'(opnd.y[BIN_W-1:HALF_W]);
        s4_next.hl  = PP_W'(opnd.x[BIN_W-1:HALF_W]) * PP_W'(opnd.y[HALF_W-1:0]);
        s4_next.hh  = PP_W'(opnd.x[BIN_W-1:HALF_W]) * PP_W'(opnd.y[BIN_W-1:HALF_W]);
    end

    always_comb
    begin
        s5_next.vld = s4_reg.vld;
        s5_next.op  = s4_reg.op;
        s5_next.bad = s4_reg.bad;
        s5_next.a   = s4_reg.a;
        s5_next.x   = s4_reg.x;
        s5_next.s   = s4_reg.s;
        s5_next.p   = {s4_reg.hh, {PP_W{1'b0}}}
                    + (P_W'(s4_reg.lh) << HALF_W)
                    + (P_W'(s4_reg.hl) << HALF_W)
                    + P_W'(s4_reg.ll);
    end

    always_comb
    begin
        logic ovf;
        s6_next.vld = s5_reg.vld;
        s6_next.op  = s5_reg.op;
        s6_next.bin = s5_reg.x;
        s6_next.bcd = '0;
        case (s5_reg.op)
            OP_BIN2BCD:
            begin
                ovf         = s5_reg.a > LIM;
                s6_next.val = s5_reg.a[BIN_W-1:0];
            end
            OP_BCD2BIN:
            begin
                ovf         = 1'b0;
                s6_next.val = '0;
            end
            OP_ADD:
            begin
                ovf         = 64'(s5_reg.s) > LIM;
                s6_next.val = s5_reg.s[BIN_W-1:0];
            end
            default:
            begin
                ovf         = s5_reg.p > P_W'(LIM);
                s6_next.val = s5_reg.p[BIN_W-1:0];
            end
        endcase
        if (s5_reg.bad)
            s6_next.err = ERR_BAD;
        else if (ovf)
            s6_next.err = ERR_OVERFLOW;
        else
            s6_next.err = ERR_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
        end
        else if (en)
        begin
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign conv = s6_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcdac_dabble_stage.sv =====
// One double-dabble stage: shifts DD_STEPS binary bits into the BCD word.
// Depends on bcdac_pkg.
`default_nettype none

module bcdac_dabble_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire bcdac_pkg::conv_t     din,
    output bcdac_pkg::conv_t          dout
);
    import bcdac_pkg::*;

    conv_t st_reg, st_next;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [BIN_W-1:0] v;
        b = din.bcd;
        v = din.val;
        for (int s = 0; s < DD_STEPS; s++)
        begin
            for (int d = 0; d < NIB_N; d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
            b = {b[BCD_W-2:0], v[BIN_W-1]};
            v = {v[BIN_W-2:0], 1'b0};
        end
        st_next     = din;
        st_next.bcd = b;
        st_next.val = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (en)
            st_reg <= st_next;
    end

    assign dout = st_reg;

endmodule

`default_nettype wire

// ===== tb/bcd_arith_convert_unit_test.sv =====
// Testbench for bcd_arith_convert_unit: directed and random BCD add, multiply and
// conversion transfers checked against an in-bench predictor. Depends on bcdac_pkg.
`timescale 1ns / 1ps

module bcd_arith_convert_unit_test;
    import bcdac_pkg::*;

    localparam int NDIG = 16;

    typedef struct packed {
        logic [63:0] value;
        err_t        err;
    } bcd_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    bcd_res_t     pending_results[$];
    int           mismatch_cnt;
    int           burst_left;
    bit           stall_mode;

    bcd_arith_convert_unit #(.DIGITS(NDIG)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] digit_limit();
        logic [63:0] m;
        m = 64'd0;
        for (int i = 0; i < NDIG && i < 16; i++)
        begin
            m = m * 64'd10 + 64'd9;
        end
        return m;
    endfunction

    function automatic bit nibbles_ok(logic [63:0] v);
        for (int i = 0; i < 16; i++)
        begin
            if (v[4*i +: 4] > 4'd9)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] bcd_to_bin(logic [63:0] v);
        logic [63:0] r;
        r = 64'd0;
        for (int i = 15; i >= 0; i--)
        begin
            r = r * 64'd10 + 64'(v[4*i +: 4]);
        end
        return r;
    endfunction

    function automatic logic [63:0] bin_to_bcd(logic [63:0] v);
        logic [63:0] r;
        r = 64'd0;
        for (int i = 0; i < 16; i++)
        begin
            r[4*i +: 4] = 4'(v % 64'd10);
            v = v / 64'd10;
        end
        return r;
    endfunction

    function automatic bcd_res_t predict_bcd_op(op_t op, logic [63:0] a, logic [63:0] b);
        bcd_res_t    r;
        logic [63:0] lim;
        logic [127:0] prod;
        lim = digit_limit();
        r.value = 64'd0;
        r.err = ERR_OK;
        case (op)
            OP_BIN2BCD:
                if (a > lim) r.err = ERR_OVERFLOW;
                else r.value = bin_to_bcd(a);
            OP_BCD2BIN:
                if (!nibbles_ok(a)) r.err = ERR_BAD;
                else r.value = bcd_to_bin(a);
            default:
                if (!nibbles_ok(a) || !nibbles_ok(b))
                    r.err = ERR_BAD;
                else
                begin
                    if (op == OP_ADD)
                        prod = 128'(bcd_to_bin(a)) + 128'(bcd_to_bin(b));
                    else
                        prod = 128'(bcd_to_bin(a)) * 128'(bcd_to_bin(b));
                    if (prod > 128'(lim)) r.err = ERR_OVERFLOW;
                    else r.value = bin_to_bcd(prod[63:0]);
                end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand_bcd(int ndig);
        logic [63:0] v;
        v = 64'd0;
        for (int i = 0; i < ndig; i++)
        begin
            v[4*i +: 4] = 4'($urandom_range(9));
        end
        return v;
    endfunction

    // mostly valid BCD of random length, some all-nines, some with one bad digit, some arbitrary bit noise
    function automatic logic [63:0] rand_operand();
        int k;
        k = $urandom_range(9);
        if (k == 0) return {$urandom, $urandom};
        if (k == 1) return rand_bcd(16) | (64'hA << (4 * $urandom_range(15)));
        if (k == 2) return bin_to_bcd(digit_limit());
        return rand_bcd($urandom_range(1, 16));
    endfunction

    task automatic send_op(op_t op, logic [63:0] a, logic [63:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        pending_results.push_back(predict_bcd_op(op, a, b));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic test_extremes();
        logic [63:0] nines;
        nines = bin_to_bcd(digit_limit());
        send_op(OP_BIN2BCD, 64'd0, 64'd0);
        send_op(OP_BIN2BCD, digit_limit(), {64{1'b1}});
        send_op(OP_BIN2BCD, digit_limit() + 64'd1, 64'd0);
        send_op(OP_BIN2BCD, {64{1'b1}}, 64'd0);
        send_op(OP_BCD2BIN, nines, {64{1'b1}});
        send_op(OP_BCD2BIN, 64'd0, 64'd0);
        send_op(OP_BCD2BIN, 64'hF000_0000_0000_0000, 64'd0);
        send_op(OP_BCD2BIN, 64'h0000_0000_0000_000A, 64'd0);
        send_op(OP_ADD, nines, 64'd0);
        send_op(OP_ADD, nines, 64'd1);
        send_op(OP_ADD, nines, nines);
        send_op(OP_ADD, 64'd5, 64'h0000_00B0_0000_0000);
        send_op(OP_MUL, nines, 64'd1);
        send_op(OP_MUL, nines, 64'd0);
        send_op(OP_MUL, nines, nines);
        send_op(OP_MUL, 64'h9999_9999, 64'h1_0000_0001);
        send_op(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
        send_op(OP_MUL, 64'h1_0000_0000, 64'h1000_0000);
        send_op(OP_MUL, {64{1'b1}}, 64'd3);
        send_op(OP_ADD, 64'h5000_0000_0000_0000, 64'h5000_0000_0000_0000);
    endtask

    task automatic test_random(int count);
        op_t op;
        for (int n = 0; n < count; n++)
        begin
            op = op_t'($urandom_range(3));
            if (op == OP_BIN2BCD)
            begin
                case ($urandom_range(2))
                    0: send_op(op, {$urandom, $urandom}, {$urandom, $urandom});
                    1: send_op(op, digit_limit() - 64'($urandom_range(3)) + 64'd1,
                               64'd0);
                    default: send_op(op, {$urandom, $urandom} % (digit_limit() + 64'd1),
                                     {$urandom, $urandom});
                endcase
            end
            else
                send_op(op, rand_operand(), rand_operand());
        end
    endtask

    // receiver stalls in two phases: light and heavy
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if ($urandom_range(63) == 0)
                stall_mode = ~stall_mode;
            m_tready <= stall_mode ? ($urandom_range(2) != 0) : ($urandom_range(9) != 0);
        end
    end

    always @(posedge clk)
    begin
        bcd_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected transfer: value %h err %0d", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.err)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %h err %0d, got %h err %0d",
                                 want.value, want.err, m_tdata, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** bcd_arith_convert_unit: FAILED **");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatch_cnt = 0;
        burst_left = 0;
        stall_mode = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_random(1650);
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("** bcd_arith_convert_unit: PASSED **");
        else
            $display("** bcd_arith_convert_unit: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/bcdac_pkg.sv
rtl/core/bcdac_decode.sv
rtl/core/bcdac_mult.sv
rtl/core/bcdac_dabble_stage.sv
rtl/core/bcd_arith_convert_unit.sv
tb/bcd_arith_convert_unit_test.sv
